// ===== rtl/stc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants of the smoothstep trilinear color sampler.
// ----------------------------------------------------------------------------

package stc_pkg;

  localparam int CellsPerAxis = 16;
  localparam int ColorBits    = 8;
  localparam int FractionBits = 12;

  localparam int CoordBits    = 16;
  localparam int FieldBits    = 8;
  localparam int IndexBits    = 12;

  localparam int Lanes        = 3;
  localparam int Corners      = 8;
  localparam int BlendSteps   = Corners - 1;
  localparam int XSteps       = Corners / 2;
  localparam int XYSteps      = XSteps + Corners / 4;

  localparam logic OpWrite  = 1'b0;
  localparam logic OpSample = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic [IndexBits-1:0] entry_index;
    logic [FieldBits-1:0] red_in;
    logic [FieldBits-1:0] green_in;
    logic [FieldBits-1:0] blue_in;
    logic [CoordBits-1:0] coord_x;
    logic [CoordBits-1:0] coord_y;
    logic [CoordBits-1:0] coord_z;
  } stc_req_t;

  typedef struct packed {
    logic [FieldBits-1:0] red;
    logic [FieldBits-1:0] green;
    logic [FieldBits-1:0] blue;
  } stc_rsp_t;

  typedef enum logic [1:0] {
    StIdle,
    StFetch,
    StBlend
  } stc_state_e;

endpackage

// ===== rtl/stc_shape.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_shape
// Smoothstep weights f*f*(3-2f) of three fractions on one shared multiplier.
// ----------------------------------------------------------------------------

module stc_shape #(
  parameter int FractionBits = stc_pkg::FractionBits
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  logic [stc_pkg::Lanes-1:0][FractionBits-1:0] frac_i,
  output logic                                        ready_o,
  output logic [stc_pkg::Lanes-1:0][FractionBits:0]   weight_o
);

  localparam int AW = 2 * FractionBits;
  localparam int BW = FractionBits + 2;
  localparam int PW = AW + BW;
  localparam logic [2:0] LastStep = 3'(2 * stc_pkg::Lanes);

  logic [2:0]                                step_q;
  logic                                      run_q;
  logic                                      ready_q;
  logic [PW-1:0]                             prod_q;
  logic [PW-1:0]                             prod_d;
  logic [stc_pkg::Lanes-1:0][FractionBits:0] weight_q;
  logic [FractionBits-1:0]                   f;
  logic [BW-1:0]                             lin;
  logic [AW-1:0]                             op_a;
  logic [BW-1:0]                             op_b;
  logic [PW:0]                               rsum;
  logic [FractionBits:0]                     s;
  logic [1:0]                                wsel;

  always_comb begin
    case (step_q[2:1])
      2'd0:    f = frac_i[0];
      2'd1:    f = frac_i[1];
      2'd2:    f = frac_i[2];
      default: f = '0;
    endcase
    lin    = (BW'(3) << FractionBits) - (BW'(f) << 1);
    op_a   = step_q[0] ? prod_q[AW-1:0] : AW'(f);
    op_b   = step_q[0] ? lin : BW'(f);
    prod_d = op_a * op_b;
    rsum   = (PW+1)'(prod_q) + ((PW+1)'(1) << (2 * FractionBits - 1));
    s      = (FractionBits+1)'(rsum >> (2 * FractionBits));
    wsel   = 2'(step_q[2:1] - 2'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      run_q   <= 1'b0;
      ready_q <= 1'b0;
    end else if (start_i) begin
      step_q  <= '0;
      run_q   <= 1'b1;
      ready_q <= 1'b0;
    end else if (run_q) begin
      step_q <= step_q + 3'd1;
      if (step_q == LastStep) begin
        run_q   <= 1'b0;
        ready_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_q) begin
      prod_q <= prod_d;
      if (step_q != '0 && !step_q[0]) begin
        weight_q[wsel] <= s;
      end
    end
  end

  assign ready_o  = ready_q;
  assign weight_o = weight_q;

endmodule

// ===== rtl/stc_lerp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_lerp
// Three-lane blend unit: a * 2^F + (b - a) * w, one registered step.
// ----------------------------------------------------------------------------

module stc_lerp #(
  parameter int ColorBits    = stc_pkg::ColorBits,
  parameter int FractionBits = stc_pkg::FractionBits
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   valid_i,
  input  logic [stc_pkg::Lanes-1:0][ColorBits+2*FractionBits-1:0] a_i,
  input  logic [stc_pkg::Lanes-1:0][ColorBits+2*FractionBits-1:0] b_i,
  input  logic [FractionBits:0]                                  w_i,
  output logic                                                   valid_o,
  output logic [stc_pkg::Lanes-1:0][ColorBits+3*FractionBits-1:0] r_o
);

  localparam int VW = ColorBits + 2 * FractionBits;
  localparam int RW = ColorBits + 3 * FractionBits;
  localparam int PW = VW + FractionBits + 3;

  logic                                 valid_q;
  logic [stc_pkg::Lanes-1:0][RW-1:0]    r_q;
  logic [stc_pkg::Lanes-1:0][RW-1:0]    r_d;
  logic signed [VW:0]                   diff;
  logic signed [FractionBits+1:0]       ws;
  logic signed [PW-1:0]                 prod;
  logic signed [PW-1:0]                 base;
  logic signed [PW-1:0]                 sum;

  always_comb begin
    diff = '0;
    prod = '0;
    base = '0;
    sum  = '0;
    ws   = $signed({1'b0, w_i});
    for (int l = 0; l < stc_pkg::Lanes; l++) begin
      diff   = $signed({1'b0, b_i[l]}) - $signed({1'b0, a_i[l]});
      prod   = PW'(diff) * PW'(ws);
      base   = $signed(PW'(a_i[l]) << FractionBits);
      sum    = base + prod;
      r_d[l] = sum[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      r_q <= r_d;
    end
  end

  assign valid_o = valid_q;
  assign r_o     = r_q;

endmodule

// ===== rtl/smoothstep_trilinear_color_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoothstep_trilinear_color_sampler
// Periodic RGB lattice with smoothstep-shaped trilinear sampling.
// ----------------------------------------------------------------------------
// A write transaction stores one lattice color and busy stays low. A sample
// transaction holds busy high and its result appears on rsp_o with valid_o
// high for one cycle, in the cycle busy falls, so a new transaction can be
// started once busy is low. The busy time comes from the eight corner reads
// through the single-port color memory, one per cycle, followed by the seven
// blend steps of the shared three-lane blend unit, which waits for a partial
// result before the last step. The smoothstep weights are formed in parallel
// with the corner reads. There is no back pressure on results: each one must
// be taken in the cycle valid_o is high.
// ----------------------------------------------------------------------------

module smoothstep_trilinear_color_sampler #(
  parameter int CellsPerAxis = stc_pkg::CellsPerAxis,
  parameter int ColorBits    = stc_pkg::ColorBits,
  parameter int FractionBits = stc_pkg::FractionBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  stc_pkg::stc_req_t req_i,
  output logic              valid_o,
  output stc_pkg::stc_rsp_t rsp_o
);

  localparam int Lanes = stc_pkg::Lanes;
  localparam int CW    = $clog2(CellsPerAxis);
  localparam int Depth = CellsPerAxis * CellsPerAxis * CellsPerAxis;
  localparam int AW    = $clog2(Depth);
  localparam int SW    = stc_pkg::CoordBits + CW;
  localparam int VW    = ColorBits + 2 * FractionBits;
  localparam int RW    = ColorBits + 3 * FractionBits;
  localparam int OW    = (ColorBits + 1 > 8) ? ColorBits + 1 : 8;
  localparam int MW    = Lanes * ColorBits;

  stc_pkg::stc_state_e state_q, state_d;

  logic [Lanes-1:0][CW-1:0]                    cell_q;
  logic [Lanes-1:0][FractionBits-1:0]          frac_q;
  logic [Lanes-1:0][CW-1:0]                    cell_d;
  logic [Lanes-1:0][FractionBits-1:0]          frac_d;
  logic [Lanes-1:0][stc_pkg::CoordBits-1:0]    coord;
  logic [SW-1:0]                               scaled;
  logic [2:0]                                  fetch_q;
  logic [MW-1:0]                               mem_q [Depth];
  logic [MW-1:0]                               rd_q;
  logic                                        rd_vld_q;
  logic                                        rd_en;
  logic                                        we_en;
  logic [AW-1:0]                               mem_addr;
  logic [MW-1:0]                               wdata;
  logic [CW-1:0]                               cx, cy, cz;
  logic                                        accept;
  logic                                        sample;
  logic [Lanes-1:0][stc_pkg::Corners-1:0][VW-1:0] q_q, q_d;
  logic [3:0]                                  cnt_q, cnt_d;
  logic [3:0]                                  pos;
  logic [2:0]                                  iss_q;
  logic [2:0]                                  res_q;
  logic                                        issue;
  logic                                        app;
  logic [Lanes-1:0][VW-1:0]                    app_data;
  logic                                        w_ready;
  logic [Lanes-1:0][FractionBits:0]            weights;
  logic [FractionBits:0]                       w_sel;
  logic                                        lerp_vld;
  logic [Lanes-1:0][RW-1:0]                    lerp_r;
  logic                                        final_step;
  logic [RW:0]                                 rsum;
  logic [OW-1:0]                               rnd;
  logic [Lanes-1:0][stc_pkg::FieldBits-1:0]    chan;
  logic                                        valid_q;
  stc_pkg::stc_rsp_t                           rsp_q;

  function automatic logic [CW-1:0] next_cell(input logic [CW-1:0] c);
    logic [CW-1:0] n;
    n = (c == CW'(CellsPerAxis - 1)) ? '0 : c + CW'(1);
    return n;
  endfunction

  // cell and fraction of each coordinate
  always_comb begin
    coord[0] = req_i.coord_x;
    coord[1] = req_i.coord_y;
    coord[2] = req_i.coord_z;
    scaled   = '0;
    for (int l = 0; l < Lanes; l++) begin
      scaled    = SW'(coord[l]) * SW'(CellsPerAxis);
      cell_d[l] = scaled[SW-1:stc_pkg::CoordBits];
      frac_d[l] = scaled[stc_pkg::CoordBits-1:stc_pkg::CoordBits-FractionBits];
    end
  end

  assign accept = start && (state_q == stc_pkg::StIdle);
  assign sample = accept && (req_i.operation == stc_pkg::OpSample);

  // corner address with wrap
  always_comb begin
    cx = fetch_q[0] ? next_cell(cell_q[0]) : cell_q[0];
    cy = fetch_q[1] ? next_cell(cell_q[1]) : cell_q[1];
    cz = fetch_q[2] ? next_cell(cell_q[2]) : cell_q[2];
  end

  always_comb begin
    state_d  = state_q;
    rd_en    = 1'b0;
    we_en    = 1'b0;
    mem_addr = AW'(cx) + AW'(cy) * AW'(CellsPerAxis)
             + AW'(cz) * AW'(CellsPerAxis * CellsPerAxis);
    wdata    = {ColorBits'(req_i.red_in), ColorBits'(req_i.green_in),
                ColorBits'(req_i.blue_in)};
    case (state_q)
      stc_pkg::StIdle: begin
        if (accept && req_i.operation == stc_pkg::OpWrite) begin
          mem_addr = AW'(req_i.entry_index);
          we_en    = 32'(req_i.entry_index) < 32'(Depth);
        end
        if (sample) begin
          state_d = stc_pkg::StFetch;
        end
      end
      stc_pkg::StFetch: begin
        rd_en = 1'b1;
        if (fetch_q == 3'(stc_pkg::Corners - 1)) begin
          state_d = stc_pkg::StBlend;
        end
      end
      stc_pkg::StBlend: begin
        if (final_step) begin
          state_d = stc_pkg::StIdle;
        end
      end
      default: state_d = stc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stc_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_en) begin
      mem_q[mem_addr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample) begin
      cell_q <= cell_d;
      frac_q <= frac_d;
    end
  end

  stc_shape #(
    .FractionBits(FractionBits)
  ) u_shape (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sample),
    .frac_i  (frac_q),
    .ready_o (w_ready),
    .weight_o(weights)
  );

  // blend queue: each step takes the two oldest values and appends its result
  always_comb begin
    issue = (state_q == stc_pkg::StBlend) && w_ready && (cnt_q >= 4'd2)
         && (iss_q < 3'(stc_pkg::BlendSteps));
    final_step = lerp_vld && (res_q == 3'(stc_pkg::BlendSteps - 1));
    app   = rd_vld_q || (lerp_vld && !final_step);
    pos   = cnt_q - (issue ? 4'd2 : 4'd0);
    if (iss_q < 3'(stc_pkg::XSteps)) begin
      w_sel = weights[0];
    end else if (iss_q < 3'(stc_pkg::XYSteps)) begin
      w_sel = weights[1];
    end else begin
      w_sel = weights[2];
    end
    for (int l = 0; l < Lanes; l++) begin
      app_data[l] = rd_vld_q ? VW'(rd_q[(Lanes-1-l)*ColorBits +: ColorBits])
                             : lerp_r[l][VW-1:0];
      q_d[l] = issue ? (q_q[l] >> (2 * VW)) : q_q[l];
      for (int e = 0; e < stc_pkg::Corners; e++) begin
        if (app && pos == 4'(e)) begin
          q_d[l][e] = app_data[l];
        end
      end
    end
    cnt_d = cnt_q - (issue ? 4'd2 : 4'd0) + (app ? 4'd1 : 4'd0);
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetch_q  <= '0;
      rd_vld_q <= 1'b0;
      cnt_q    <= '0;
      iss_q    <= '0;
      res_q    <= '0;
      valid_q  <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      valid_q  <= final_step;
      if (sample) begin
        fetch_q <= '0;
        cnt_q   <= '0;
        iss_q   <= '0;
        res_q   <= '0;
      end else begin
        if (rd_en) begin
          fetch_q <= fetch_q + 3'd1;
        end
        cnt_q <= cnt_d;
        if (issue) begin
          iss_q <= iss_q + 3'd1;
        end
        if (lerp_vld) begin
          res_q <= res_q + 3'd1;
        end
      end
    end
  end

  stc_lerp #(
    .ColorBits   (ColorBits),
    .FractionBits(FractionBits)
  ) u_lerp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(issue),
    .a_i    ({q_q[2][0], q_q[1][0], q_q[0][0]}),
    .b_i    ({q_q[2][1], q_q[1][1], q_q[0][1]}),
    .w_i    (w_sel),
    .valid_o(lerp_vld),
    .r_o    (lerp_r)
  );

  // round to nearest and cut to the output field
  always_comb begin
    rsum = '0;
    rnd  = '0;
    for (int l = 0; l < Lanes; l++) begin
      rsum    = (RW+1)'(lerp_r[l]) + ((RW+1)'(1) << (3 * FractionBits - 1));
      rnd     = OW'(rsum >> (3 * FractionBits));
      chan[l] = rnd[stc_pkg::FieldBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (final_step) begin
      rsp_q.red   <= chan[0];
      rsp_q.green <= chan[1];
      rsp_q.blue  <= chan[2];
    end
  end

  assign busy    = (state_q != stc_pkg::StIdle);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'(stc_pkg::Corners))
    else $error("blend queue overflow");

  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == stc_pkg::StBlend))
    else $error("result strobe outside blend");

  a_lerp_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lerp_vld |-> state_q == stc_pkg::StBlend)
    else $error("blend result outside blend");

  a_sample_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample |=> busy && fetch_q == 3'd0 && state_q == stc_pkg::StFetch)
    else $error("sample transaction did not start fetch");

endmodule

// ===== dv/smoothstep_trilinear_color_sampler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoothstep_trilinear_color_sampler_tb
// Self-checking bench for the periodic RGB lattice sampler. A short table of
// lattice writes and samples around the origin cell and the wrap cell comes
// first. Then a small block of lattice entries around the wrap corner is
// filled, and a random mix of samples within that block and writes, most
// of them into it, follows. Every sample result is checked field by field
// against a set color or a smoothstep trilinear blend of a shadow lattice.
// ----------------------------------------------------------------------------

module smoothstep_trilinear_color_sampler_tb;

  localparam int LatticeDepth = stc_pkg::CellsPerAxis * stc_pkg::CellsPerAxis
                              * stc_pkg::CellsPerAxis;
  localparam longint unsigned OneWeight = 64'd1 << stc_pkg::FractionBits;
  localparam int IdxW        = stc_pkg::IndexBits;
  localparam int RegionSpan  = 5;
  localparam int RegionSize  = RegionSpan * RegionSpan * RegionSpan;
  localparam int RandomItems = 1350;
  localparam int QuietTail   = 200;

  typedef struct {
    stc_pkg::stc_req_t req;
    bit                typed;
    stc_pkg::stc_rsp_t want;
  } directed_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  stc_pkg::stc_req_t req_i;
  logic              valid_o;
  stc_pkg::stc_rsp_t rsp_o;

  bit [7:0]          lattice_color [3][LatticeDepth];
  stc_pkg::stc_rsp_t pending_colors [$];
  directed_row_t     directed_rows [$];
  int                mismatch_count = 0;

  smoothstep_trilinear_color_sampler DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #8ms;
    $display("status: fail");
    $finish;
  end

  function automatic bit [63:0] smooth_weight(input bit [63:0] f);
    bit [63:0] ff;
    bit [63:0] lin;
    ff  = f * f;
    lin = 3 * OneWeight - 2 * f;
    return (ff * lin + (64'd1 << (2 * stc_pkg::FractionBits - 1)))
           >> (2 * stc_pkg::FractionBits);
  endfunction

  function automatic stc_pkg::stc_rsp_t blend_sample(input stc_pkg::stc_req_t req);
    bit [15:0]         crd [3];
    bit [63:0]         base_cell [3];
    bit [63:0]         nxt [3];
    bit [63:0]         w0 [3];
    bit [63:0]         w1 [3];
    bit [63:0]         scaled;
    bit [63:0]         s;
    bit [63:0]         acc;
    bit [63:0]         wgt;
    bit [7:0]          chan [3];
    int                idx;
    stc_pkg::stc_rsp_t res;
    crd[0] = req.coord_x;
    crd[1] = req.coord_y;
    crd[2] = req.coord_z;
    for (int a = 0; a < 3; a++) begin
      scaled       = 64'(crd[a]) * stc_pkg::CellsPerAxis;
      base_cell[a] = scaled >> 16;
      s            = smooth_weight((scaled & 64'hFFFF) >> (16 - stc_pkg::FractionBits));
      w1[a]        = s;
      w0[a]        = OneWeight - s;
      nxt[a]       = (base_cell[a] + 1 >= stc_pkg::CellsPerAxis) ? 64'd0 : base_cell[a] + 1;
    end
    for (int ch = 0; ch < 3; ch++) begin
      acc = 0;
      for (int k = 0; k < 2; k++) begin
        for (int j = 0; j < 2; j++) begin
          for (int i = 0; i < 2; i++) begin
            idx = int'((i ? nxt[0] : base_cell[0]) + stc_pkg::CellsPerAxis *
                  ((j ? nxt[1] : base_cell[1]) +
                   stc_pkg::CellsPerAxis * (k ? nxt[2] : base_cell[2])));
            wgt = (i ? w1[0] : w0[0]) * (j ? w1[1] : w0[1]) * (k ? w1[2] : w0[2]);
            acc += 64'(lattice_color[ch][idx]) * wgt;
          end
        end
      end
      acc = (acc + (64'd1 << (3 * stc_pkg::FractionBits - 1))) >> (3 * stc_pkg::FractionBits);
      chan[ch] = acc[7:0];
    end
    res.red   = chan[0];
    res.green = chan[1];
    res.blue  = chan[2];
    return res;
  endfunction

  // entry n of the block of cells 15, 0, 1, 2, 3 on each axis
  function automatic int region_index(input int n);
    int ax;
    int ay;
    int az;
    ax = (n % RegionSpan + stc_pkg::CellsPerAxis - 1) % stc_pkg::CellsPerAxis;
    ay = ((n / RegionSpan) % RegionSpan + stc_pkg::CellsPerAxis - 1)
         % stc_pkg::CellsPerAxis;
    az = ((n / (RegionSpan * RegionSpan)) % RegionSpan + stc_pkg::CellsPerAxis - 1)
         % stc_pkg::CellsPerAxis;
    return ax + stc_pkg::CellsPerAxis * (ay + stc_pkg::CellsPerAxis * az);
  endfunction

  function automatic void add_write(input int idx, input bit [23:0] rgb);
    directed_row_t row;
    row.req             = '0;
    row.req.operation   = stc_pkg::OpWrite;
    row.req.entry_index = IdxW'(idx);
    row.req.red_in      = rgb[23:16];
    row.req.green_in    = rgb[15:8];
    row.req.blue_in     = rgb[7:0];
    row.typed           = 1'b0;
    row.want            = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_sample(input bit [15:0] x, input bit [15:0] y,
                                     input bit [15:0] z, input bit typed,
                                     input bit [23:0] want);
    directed_row_t row;
    row.req           = '0;
    row.req.operation = stc_pkg::OpSample;
    row.req.coord_x   = x;
    row.req.coord_y   = y;
    row.req.coord_z   = z;
    row.typed         = typed;
    row.want          = want;
    directed_rows.push_back(row);
  endfunction

  // cell 15, 0, 1 or 2, so every corner lies in the filled block
  function automatic bit [15:0] rand_coord();
    bit [3:0]  c;
    bit [11:0] r;
    c = 4'(($urandom_range(0, RegionSpan - 2) + stc_pkg::CellsPerAxis - 1)
           % stc_pkg::CellsPerAxis);
    r = 12'($urandom);
    case ($urandom_range(0, 5))
      0: return {c, 12'h000};
      1: return {c, 12'hFFF};
      2: return {c, 12'h800};
      default: return {c, r};
    endcase
  endfunction

  function automatic stc_pkg::stc_req_t random_req();
    stc_pkg::stc_req_t req;
    req.operation   = ($urandom_range(0, 9) < 4) ? stc_pkg::OpWrite : stc_pkg::OpSample;
    req.entry_index = ($urandom_range(0, 3) == 0) ? IdxW'($urandom)
                    : IdxW'(region_index($urandom_range(0, RegionSize - 1)));
    req.red_in      = 8'($urandom);
    req.green_in    = 8'($urandom);
    req.blue_in     = 8'($urandom);
    req.coord_x     = rand_coord();
    req.coord_y     = rand_coord();
    req.coord_z     = rand_coord();
    return req;
  endfunction

  task automatic issue(input stc_pkg::stc_req_t req, input bit typed,
                       input stc_pkg::stc_rsp_t want);
    start <= 1'b1;
    req_i <= req;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (req.operation == stc_pkg::OpSample) begin
      pending_colors.push_back(typed ? want : blend_sample(req));
    end else begin
      lattice_color[0][req.entry_index] = req.red_in;
      lattice_color[1][req.entry_index] = req.green_in;
      lattice_color[2][req.entry_index] = req.blue_in;
    end
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_colors.size() != 0) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    stc_pkg::stc_rsp_t want;
    if (rst_ni === 1'b1 && valid_o !== 1'b0) begin
      if (pending_colors.size() == 0) begin
        $error("unexpected transaction: red %0d green %0d blue %0d",
               rsp_o.red, rsp_o.green, rsp_o.blue);
        mismatch_count++;
      end else begin
        want = pending_colors.pop_front();
        if (rsp_o.red !== want.red) begin
          $error("red: expected %0d, actual %0d", want.red, rsp_o.red);
          mismatch_count++;
        end
        if (rsp_o.green !== want.green) begin
          $error("green: expected %0d, actual %0d", want.green, rsp_o.green);
          mismatch_count++;
        end
        if (rsp_o.blue !== want.blue) begin
          $error("blue: expected %0d, actual %0d", want.blue, rsp_o.blue);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    stc_pkg::stc_req_t req;
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;

    // origin cell corners
    add_write(0, 24'hFF0080);
    add_write(1, 24'h010203);
    add_write(16, 24'h102030);
    add_write(17, 24'hFFFFFF);
    add_write(256, 24'h000000);
    add_write(257, 24'h8040C0);
    add_write(272, 24'h7FFE01);
    add_write(273, 24'h55AA33);
    // last cell corners, wrapping to zero
    add_write(15, 24'h123456);
    add_write(240, 24'h9ABCDE);
    add_write(255, 24'hFEDCBA);
    add_write(3840, 24'h0FF03C);
    add_write(3855, 24'hC35AA5);
    add_write(4080, 24'h669911);
    add_write(4095, 24'hABCDEF);
    add_sample(16'h0000, 16'h0000, 16'h0000, 1'b1, 24'hFF0080);
    add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 24'hFF0080);
    add_sample(16'hF000, 16'hF000, 16'hF000, 1'b1, 24'hABCDEF);
    add_sample(16'h0800, 16'h0800, 16'h0800, 1'b0, '0);
    add_sample(16'h0FFF, 16'h0001, 16'h0800, 1'b0, '0);
    add_sample(16'hF800, 16'hFC00, 16'hF400, 1'b0, '0);
    add_sample(16'h0400, 16'h0C00, 16'h0000, 1'b0, '0);
    add_write(0, 24'h00FF01);
    add_sample(16'h0000, 16'h0000, 16'h0000, 1'b1, 24'h00FF01);
    add_sample(16'hFFFF, 16'hFFFF, 16'hF000, 1'b1, 24'h0FF03C);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[n]) begin
      issue(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].want);
      if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 11));
    end
    drain();

    // fill the block so any random sample position is legal
    for (int n = 0; n < RegionSize; n++) begin
      req             = random_req();
      req.operation   = stc_pkg::OpWrite;
      req.entry_index = IdxW'(region_index(n));
      issue(req, 1'b0, '0);
      if ($urandom_range(0, 15) == 0) pause($urandom_range(1, 11));
    end
    drain();

    for (int n = 0; n < RandomItems; n++) begin
      issue(random_req(), 1'b0, '0);
      if (n == RandomItems / 2) begin
        drain();
      end else if (n < RandomItems - QuietTail && $urandom_range(0, 5) == 0) begin
        pause($urandom_range(1, 11));
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && pending_colors.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== smoothstep_trilinear_color_sampler.f =====
rtl/stc_pkg.sv
rtl/stc_shape.sv
rtl/stc_lerp.sv
rtl/smoothstep_trilinear_color_sampler.sv
dv/smoothstep_trilinear_color_sampler_tb.sv
